FILE: rtl/core/tbla_pkg.sv
package tbla_pkg;

  // default table depths
  localparam int unsigned TENSOR_SLOTS_DEF = 64;
  localparam int unsigned BLOCK_SLOTS_DEF  = 32;

  // event codes
  typedef enum logic [1:0] {
    CMD_PRODUCE = 2'd0,
    CMD_INPLACE = 2'd1,
    CMD_CONSUME = 2'd2
  } cmd_e;

  // result codes
  typedef enum logic [2:0] {
    ST_REUSED     = 3'd0,
    ST_NEW        = 3'd1,
    ST_INPLACE    = 3'd2,
    ST_SRC_ABSENT = 3'd3,
    ST_LIVE       = 3'd4,
    ST_RELEASED   = 3'd5,
    ST_KEY_ABSENT = 3'd6,
    ST_FULL       = 3'd7
  } status_e;

  // one event
  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] tensor_key;
    logic [15:0] source_key;
    logic [30:0] size_bytes;
    logic [7:0]  use_count;
  } in_item_t;

  // one result
  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  block_index;
    logic [30:0] block_max_size;
  } out_item_t;

endpackage

FILE: rtl/core/tensor_buffer_lifetime_allocator_top.sv
// Buffer reuse planner for a stream of tensor produce and consume events.
// Input channel in_valid_i / in_stall_o / in_item_i carries one event per
// transfer; output channel out_valid_o / out_stall_i / out_item_o returns
// exactly one result per produce, in-place produce or consume event. An
// event with an unused command code is taken and yields no result.
// One event is worked on at a time; in_stall_o is high from the transfer
// until the result has been handed to the output register. A single
// compare unit walks the tables, one entry per step:
//   produce:  walk the record table for the first free record slot,
//             then check the pool blocks in use in order, reusing the
//             first fully freed one, else append a block or report the
//             pool full; a full record table is reported full
//   in-place produce and consume: search the records for the key, then
//             look up its block and update on a hit, or report the key
//             absent
// The output register holds a finished result while out_stall_i is high;
// the next event is taken meanwhile, and its result waits in the
// sequencer until the output register is free.
// Reset clears all record valid bits and the pool block count at once;
// record and block contents are written before they are ever used.
module tensor_buffer_lifetime_allocator_top
  import tbla_pkg::*;
#(
  parameter int unsigned TENSOR_SLOTS = TENSOR_SLOTS_DEF,
  parameter int unsigned BLOCK_SLOTS  = BLOCK_SLOTS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned TW  = (TENSOR_SLOTS > 1) ? $clog2(TENSOR_SLOTS) : 1;
  localparam int unsigned BW  = (BLOCK_SLOTS > 1) ? $clog2(BLOCK_SLOTS) : 1;
  localparam int unsigned BCW = $clog2(BLOCK_SLOTS + 1);

  typedef struct packed {
    logic [15:0]   key;
    logic [BW-1:0] blk;
    logic [7:0]    uses;
  } rec_t;

  typedef struct packed {
    logic [15:0] alloc;
    logic [15:0] free;
    logic [30:0] largest;
  } blk_t;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_FREE  = 10'b0000000010,
    S_BREAD = 10'b0000000100,
    S_BCHK  = 10'b0000001000,
    S_BNEW  = 10'b0000010000,
    S_RREAD = 10'b0000100000,
    S_RCHK  = 10'b0001000000,
    S_BLOOK = 10'b0010000000,
    S_FIN   = 10'b0100000000,
    S_PUSH  = 10'b1000000000
  } state_e;

  // memories
  rec_t rec_mem [TENSOR_SLOTS];
  blk_t blk_mem [BLOCK_SLOTS];
  rec_t rec_rd_q;
  blk_t blk_rd_q;

  state_e            state_q, state_d;
  logic [TW-1:0]     idx_q, idx_d;
  logic [BCW-1:0]    bidx_q, bidx_d;
  logic [TW-1:0]     slot_q, slot_d;
  logic [BW-1:0]     fblk_q, fblk_d;
  logic [BCW-1:0]    biu_q, biu_d;
  logic [TENSOR_SLOTS-1:0] valid_q, valid_d;
  in_item_t          item_q, item_d;
  out_item_t         res_q, res_d;
  out_item_t         out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic          rec_we;
  logic [TW-1:0] rec_waddr;
  rec_t          rec_wdata;
  logic          blk_we;
  logic [BW-1:0] blk_waddr;
  blk_t          blk_wdata;
  logic [BW-1:0] blk_raddr;

  logic          in_xfer;
  logic          search_hit;
  logic [15:0]   search_key;
  logic [30:0]   largest_new;
  logic [31:0]   bidx_ext;
  logic [31:0]   biu_ext;
  logic [31:0]   fblk_ext;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // search key and compare unit
  assign search_key  = (item_q.command == CMD_INPLACE) ? item_q.source_key
                                                       : item_q.tensor_key;
  assign search_hit  = valid_q[idx_q] && (rec_rd_q.key == search_key);
  assign largest_new = (blk_rd_q.largest < item_q.size_bytes) ? item_q.size_bytes
                                                               : blk_rd_q.largest;
  assign bidx_ext    = 32'(bidx_q);
  assign biu_ext     = 32'(biu_q);
  assign fblk_ext    = 32'(fblk_q);
  assign blk_raddr   = (state_q == S_BLOOK || state_q == S_FIN) ? fblk_q
                                                                 : bidx_q[BW-1:0];

  // sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    bidx_d      = bidx_q;
    slot_d      = slot_q;
    fblk_d      = fblk_q;
    biu_d       = biu_q;
    valid_d     = valid_q;
    item_d      = item_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    rec_we      = 1'b0;
    rec_waddr   = idx_q;
    rec_wdata   = rec_rd_q;
    blk_we      = 1'b0;
    blk_waddr   = fblk_q;
    blk_wdata   = blk_rd_q;

    // output register drains on a transfer
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          item_d = in_item_i;
          idx_d  = '0;
          bidx_d = '0;
          case (in_item_i.command)
            CMD_PRODUCE: state_d = S_FREE;
            CMD_INPLACE: state_d = S_RREAD;
            CMD_CONSUME: state_d = S_RREAD;
            default:     state_d = S_IDLE;
          endcase
        end
      end

      // first free record slot
      S_FREE: begin
        if (!valid_q[idx_q]) begin
          slot_d  = idx_q;
          state_d = S_BREAD;
        end else if (idx_q == TW'(TENSOR_SLOTS - 1)) begin
          res_d   = '{status: ST_FULL, block_index: '0, block_max_size: '0};
          state_d = S_PUSH;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      // first-fit walk over blocks in use
      S_BREAD: begin
        if (bidx_q == biu_q) begin
          state_d = S_BNEW;
        end else begin
          state_d = S_BCHK;
        end
      end

      S_BCHK: begin
        if (blk_rd_q.alloc == blk_rd_q.free) begin
          blk_we    = 1'b1;
          blk_waddr = bidx_q[BW-1:0];
          blk_wdata = '{alloc: blk_rd_q.alloc + 16'd1, free: blk_rd_q.free,
                        largest: largest_new};
          rec_we    = 1'b1;
          rec_waddr = slot_q;
          rec_wdata = '{key: item_q.tensor_key, blk: bidx_q[BW-1:0],
                        uses: item_q.use_count};
          valid_d[slot_q] = 1'b1;
          res_d   = '{status: ST_REUSED, block_index: bidx_ext[4:0],
                      block_max_size: largest_new};
          state_d = S_PUSH;
        end else begin
          bidx_d  = bidx_q + 1'b1;
          state_d = S_BREAD;
        end
      end

      // append a new block
      S_BNEW: begin
        if (biu_q == BCW'(BLOCK_SLOTS)) begin
          res_d = '{status: ST_FULL, block_index: '0, block_max_size: '0};
        end else begin
          blk_we    = 1'b1;
          blk_waddr = biu_q[BW-1:0];
          blk_wdata = '{alloc: 16'd1, free: 16'd0, largest: item_q.size_bytes};
          rec_we    = 1'b1;
          rec_waddr = slot_q;
          rec_wdata = '{key: item_q.tensor_key, blk: biu_q[BW-1:0],
                        uses: item_q.use_count};
          valid_d[slot_q] = 1'b1;
          biu_d = biu_q + 1'b1;
          res_d = '{status: ST_NEW, block_index: biu_ext[4:0],
                    block_max_size: item_q.size_bytes};
        end
        state_d = S_PUSH;
      end

      // key search over the record table
      S_RREAD: begin
        state_d = S_RCHK;
      end

      S_RCHK: begin
        if (search_hit) begin
          fblk_d  = rec_rd_q.blk;
          state_d = S_BLOOK;
        end else if (idx_q == TW'(TENSOR_SLOTS - 1)) begin
          res_d.status = (item_q.command == CMD_INPLACE) ? ST_SRC_ABSENT
                                                         : ST_KEY_ABSENT;
          res_d.block_index    = '0;
          res_d.block_max_size = '0;
          state_d = S_PUSH;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_RREAD;
        end
      end

      S_BLOOK: begin
        state_d = S_FIN;
      end

      // update the record of the found tensor, and its block on a release
      S_FIN: begin
        res_d.block_index    = fblk_ext[4:0];
        res_d.block_max_size = blk_rd_q.largest;
        rec_we = 1'b1;
        if (item_q.command == CMD_INPLACE) begin
          rec_wdata    = '{key: item_q.tensor_key, blk: rec_rd_q.blk,
                           uses: item_q.use_count};
          res_d.status = ST_INPLACE;
        end else if (rec_rd_q.uses <= 8'd1) begin
          rec_wdata      = '{key: rec_rd_q.key, blk: rec_rd_q.blk, uses: 8'd0};
          valid_d[idx_q] = 1'b0;
          blk_we         = 1'b1;
          blk_wdata      = '{alloc: blk_rd_q.alloc, free: blk_rd_q.free + 16'd1,
                             largest: blk_rd_q.largest};
          res_d.status   = ST_RELEASED;
        end else begin
          rec_wdata    = '{key: rec_rd_q.key, blk: rec_rd_q.blk,
                           uses: rec_rd_q.uses - 8'd1};
          res_d.status = ST_LIVE;
        end
        state_d = S_PUSH;
      end

      // hand result to the output register once it is free
      S_PUSH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      bidx_q      <= '0;
      slot_q      <= '0;
      fblk_q      <= '0;
      biu_q       <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      bidx_q      <= bidx_d;
      slot_q      <= slot_d;
      fblk_q      <= fblk_d;
      biu_q       <= biu_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  // record memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (rec_we) begin
      rec_mem[rec_waddr] <= rec_wdata;
    end
    rec_rd_q <= rec_mem[idx_q];
  end

  // block memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (blk_we) begin
      blk_mem[blk_waddr] <= blk_wdata;
    end
    blk_rd_q <= blk_mem[blk_raddr];
  end

  // pool never grows past its depth
  a_biu_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    biu_q <= BCW'(BLOCK_SLOTS))
    else $error("pool block count beyond depth");

  // block walk stays within blocks in use
  a_bidx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BREAD || state_q == S_BCHK) |-> bidx_q <= biu_q)
    else $error("block walk past blocks in use");

  // appending a block bumps the count by one
  a_biu_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BNEW && biu_q != BCW'(BLOCK_SLOTS)) |=>
      biu_q == $past(biu_q) + 1'b1)
    else $error("new block did not advance pool count");

  // a release drops exactly one record
  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && item_q.command == CMD_CONSUME && rec_rd_q.uses <= 8'd1)
      |=> $countones(valid_q) == $past($countones(valid_q)) - 1)
    else $error("release did not clear one record");

  // a pushed result reaches the output register
  a_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUSH && !out_valid_q) |=> (out_valid_q && state_q == S_IDLE))
    else $error("result not loaded into output register");

endmodule
